[hdl/rws_pkg.sv]
package rws_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int EIU_W = 7;

   // Register index as decoded from paddr bit 2.
   localparam logic REG_ENTRIES_IN_USE = 1'b0;
   localparam logic [EIU_W-1:0] ENTRIES_RESET = 7'd64;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_DRAW = 1'b1;

   localparam int SCALE_THOUSAND = 1000;
   localparam int DRAW_W = 10;
   localparam int INDEX_W = 6;
   localparam int FIT_IN_W = 16;

   typedef struct packed {
      logic load_we;
      logic draw_start;
      logic sum_acc;
      logic mul;
      logic walk_acc;
      logic idx_inc;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic hit;
   } status_type;

endpackage

[hdl/rws_ctrl.sv]
module rws_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_kind,
   input  rws_pkg::status_type status,
   output rws_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_valid
);
   import rws_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      SUM_RD,
      SUM_ACC,
      MUL,
      WALK_RD,
      WALK_ACC,
      WALK_END
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            cmd.load_we = start && (req_kind == KIND_LOAD);
            cmd.draw_start = start && (req_kind == KIND_DRAW);
            if (cmd.draw_start) begin
               state_in = SUM_RD;
            end
         end
         SUM_RD: begin
            state_in = SUM_ACC;
         end
         SUM_ACC: begin
            cmd.sum_acc = 1'b1;
            cmd.idx_inc = !status.last;
            state_in = status.last ? MUL : SUM_RD;
         end
         MUL: begin
            cmd.mul = 1'b1;
            state_in = WALK_RD;
         end
         WALK_RD: begin
            // The scaled prefix now covers every entry before the one being read.
            cmd.emit = status.hit;
            state_in = status.hit ? IDLE : WALK_ACC;
         end
         WALK_ACC: begin
            cmd.walk_acc = 1'b1;
            cmd.idx_inc = !status.last;
            state_in = status.last ? WALK_END : WALK_RD;
         end
         WALK_END: begin
            cmd.emit = 1'b1;
            state_in = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
      rsp_valid_in = cmd.emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_draw_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == IDLE && start && req_kind == KIND_DRAW) |=> state_ff == SUM_RD)
      else $error("accepted draw item did not start the sum pass");

   a_result_ends_draw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == IDLE)
      else $error("result shown while a draw is still running");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("more than one result for a draw item");

   a_load_no_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == IDLE && start && req_kind == KIND_LOAD) |=> !busy)
      else $error("load item made the block busy");

endmodule

[hdl/rws_datapath.sv]
module rws_datapath #(
   parameter int MAX_ENTRIES = 64,
   parameter int FITNESS_BITS = 16
) (
   input  logic                                clock,
   input  rws_pkg::cmd_type                    cmd,
   input  logic [rws_pkg::INDEX_W-1:0]         req_entry_index,
   input  logic [rws_pkg::FIT_IN_W-1:0]        req_fitness,
   input  logic [rws_pkg::DRAW_W-1:0]          req_draw,
   input  logic [rws_pkg::EIU_W-1:0]           entries_in_use,
   output rws_pkg::status_type                 status,
   output logic [rws_pkg::INDEX_W-1:0]         rsp_chosen_index,
   output logic                                rsp_fallback
);
   import rws_pkg::*;

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int SUM_W = FITNESS_BITS + IDX_W;
   localparam int LHS_W = SUM_W + DRAW_W;

   logic [FITNESS_BITS-1:0] fitness_mem [MAX_ENTRIES];
   logic [FITNESS_BITS-1:0] rd_data_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic [IDX_W-1:0]        prev_idx_ff;
   logic [DRAW_W-1:0]       draw_ff;
   logic [SUM_W-1:0]        total_ff;
   logic [LHS_W-1:0]        lhs_ff;
   logic [LHS_W-1:0]        scaled_ff;
   logic [INDEX_W-1:0]      chosen_ff;
   logic                    fallback_ff;

   logic [31:0]             wr_addr_ext;
   logic [31:0]             fit_ext;
   logic [31:0]             eiu_ext;
   logic [31:0]             last_wide;
   logic [31:0]             prev_ext;
   logic                    wr_ok;
   logic [IDX_W-1:0]        last_idx;

   assign wr_addr_ext = 32'(req_entry_index);
   assign fit_ext = 32'(req_fitness);
   assign wr_ok = (wr_addr_ext < 32'(MAX_ENTRIES));
   assign eiu_ext = 32'(entries_in_use);
   assign prev_ext = 32'(prev_idx_ff);

   // Zero entries in use counts as one; anything above the store size is clamped.
   always_comb begin
      if (eiu_ext == 32'd0) begin
         last_wide = 32'd0;
      end else if (eiu_ext > 32'(MAX_ENTRIES)) begin
         last_wide = 32'(MAX_ENTRIES - 1);
      end else begin
         last_wide = eiu_ext - 32'd1;
      end
   end
   assign last_idx = last_wide[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_we && wr_ok) begin
         fitness_mem[wr_addr_ext[IDX_W-1:0]] <= fit_ext[FITNESS_BITS-1:0];
      end
      rd_data_ff <= fitness_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.draw_start) begin
         draw_ff <= req_draw;
         total_ff <= '0;
         idx_ff <= '0;
      end else if (cmd.mul) begin
         lhs_ff <= LHS_W'(draw_ff) * LHS_W'(total_ff);
         scaled_ff <= '0;
         idx_ff <= '0;
      end else begin
         if (cmd.sum_acc) begin
            total_ff <= total_ff + SUM_W'(rd_data_ff);
         end
         if (cmd.walk_acc) begin
            scaled_ff <= scaled_ff + LHS_W'(rd_data_ff) * LHS_W'(SCALE_THOUSAND);
            prev_idx_ff <= idx_ff;
         end
         if (cmd.idx_inc) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
      end
      if (cmd.emit) begin
         chosen_ff <= prev_ext[INDEX_W-1:0];
         fallback_ff <= !status.hit;
      end
   end

   assign status.last = (idx_ff == last_idx);
   assign status.hit = (lhs_ff < scaled_ff);
   assign rsp_chosen_index = chosen_ff;
   assign rsp_fallback = fallback_ff;

endmodule

[hdl/roulette_wheel_selector_top.sv]
// Fitness-proportional selector. A load item (kind 0) writes a fitness into one
// entry and busy stays low. A draw item (kind 1) sums the entries in use and
// then walks their prefix sums, picking the first entry whose prefix, times
// 1000, exceeds draw times the total. Both passes share the single read port of
// the fitness store. Busy stays high through a draw, which ends with one cycle
// of rsp_valid. The receiver must take the result in that cycle. If no prefix
// passes, the last entry in use is returned with rsp_fallback set. Entries
// must be loaded before a draw reads them.
module roulette_wheel_selector_top #(
   parameter int MAX_ENTRIES = 64,
   parameter int FITNESS_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_kind,
   input  logic [rws_pkg::INDEX_W-1:0]        req_entry_index,
   input  logic [rws_pkg::FIT_IN_W-1:0]       req_fitness,
   input  logic [rws_pkg::DRAW_W-1:0]         req_draw,
   output logic                               rsp_valid,
   output logic [rws_pkg::INDEX_W-1:0]        rsp_chosen_index,
   output logic                               rsp_fallback,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rws_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [rws_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [rws_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   import rws_pkg::*;

   logic [EIU_W-1:0] entries_in_use_ff;
   logic             csr_write;
   cmd_type          cmd;
   status_type       status;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == REG_ENTRIES_IN_USE);

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_in_use_ff <= ENTRIES_RESET;
      end else if (csr_write) begin
         entries_in_use_ff <= pwdata[EIU_W-1:0];
      end
   end

   always_comb begin
      if (paddr[2] == REG_ENTRIES_IN_USE) begin
         prdata = CSR_DATA_W'(entries_in_use_ff);
      end else begin
         prdata = '0;
      end
   end

   rws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_kind  (req_kind),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   rws_datapath #(
      .MAX_ENTRIES  (MAX_ENTRIES),
      .FITNESS_BITS (FITNESS_BITS)
   ) u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .req_entry_index  (req_entry_index),
      .req_fitness      (req_fitness),
      .req_draw         (req_draw),
      .entries_in_use   (entries_in_use_ff),
      .status           (status),
      .rsp_chosen_index (rsp_chosen_index),
      .rsp_fallback     (rsp_fallback)
   );

endmodule
